// File: rtl/core/wrs_pkg.sv
// Shared types, constants and helper functions for the registry scanner.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package wrs_pkg;

  // Interface name buffer and character index width
  localparam int NAME_BUFFER = 32;
  localparam int CHAR_IDX_W  = $clog2(NAME_BUFFER);

  localparam int HEADER_BYTES   = 8;
  localparam int MIN_GLOBAL_SIZE = 16;
  localparam int IFACE_COUNT    = 4;
  localparam int IFACE_TEXT_W   = 128;

  localparam logic [15:0] GLOBAL_COUNT_MAX = 16'hffff;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // Configuration register indexes
  localparam int          CFG_INDEX_W         = 2;
  localparam logic [1:0]  CFG_REGISTRY_OBJECT = 2'd0;
  localparam logic [1:0]  CFG_CALLBACK_OBJECT = 2'd1;
  localparam logic [31:0] REGISTRY_RESET      = 32'd2;
  localparam logic [31:0] CALLBACK_RESET      = 32'd3;

  // Interface match codes
  localparam logic [2:0] MATCH_NONE       = 3'd0;
  localparam logic [2:0] MATCH_COMPOSITOR = 3'd1;
  localparam logic [2:0] MATCH_SHM        = 3'd2;
  localparam logic [2:0] MATCH_WM_BASE    = 3'd3;
  localparam logic [2:0] MATCH_SEAT       = 3'd4;

  // Output stream layout
  localparam int OUT_DATA_W   = 248;
  localparam int OFS_OBJECT   = 0;
  localparam int OFS_OPCODE   = 32;
  localparam int OFS_BODY_LEN = 48;
  localparam int OFS_MATCH    = 64;
  localparam int OFS_GNAME    = 67;
  localparam int OFS_COUNT    = 99;
  localparam int OFS_FOUND    = 115;
  localparam int USED_DATA_W  = 243;

  typedef enum logic [1:0] {
    KIND_OTHER     = 2'd0,
    KIND_GLOBAL    = 2'd1,
    KIND_DONE      = 2'd2,
    KIND_MALFORMED = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    PHASE_SCAN = 2'd0,
    PHASE_DONE = 2'd1,
    PHASE_ERR  = 2'd2
  } phase_t;

  // One classified message, front to back
  typedef struct packed {
    logic [31:0] object_id;
    logic [15:0] opcode;
    logic [15:0] body_length;
    kind_t       kind;
    logic [2:0]  iface_match;
    logic [31:0] global_name;
  } msg_t;

  // One finished result, back to top
  typedef struct packed {
    msg_t        msg;
    logic [15:0] global_count;
    logic [31:0] compositor_global;
    logic [31:0] shm_global;
    logic [31:0] wm_base_global;
    logic [31:0] seat_global;
  } result_t;

  // Known interface names, first character in the top byte
  localparam logic [IFACE_TEXT_W-1:0] IFACE_TEXT [IFACE_COUNT] = '{
    {"wl_", "compositor", 24'h0},
    {"wl_shm",            80'h0},
    {"xdg_", "wm_base",   40'h0},
    {"wl_seat",           72'h0}
  };

  localparam logic [CHAR_IDX_W-1:0] IFACE_LEN [IFACE_COUNT] = '{
    CHAR_IDX_W'(13), CHAR_IDX_W'(6), CHAR_IDX_W'(11), CHAR_IDX_W'(7)
  };

  // Character idx of interface sel; zero past the text
  function automatic logic [7:0] iface_char(input logic [1:0] sel,
                                            input logic [CHAR_IDX_W-1:0] idx);
    logic [IFACE_TEXT_W-1:0] shifted;
    shifted = IFACE_TEXT[sel] << {idx, 3'b000};
    return shifted[IFACE_TEXT_W-1 -: 8];
  endfunction

endpackage

// File: rtl/core/wrs_front.sv
// Front end: frames the byte stream into messages and classifies them.
// Holds the configuration registers; depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_front import wrs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   byte_valid,
  input  logic [7:0]             stream_byte,
  input  logic                   queue_full,
  output logic                   byte_ready,
  output logic                   push,
  output msg_t                   push_msg
);

  logic [31:0]           registry_object;
  logic [31:0]           callback_object;

  phase_t                phase, phase_next;
  logic [63:0]           header, header_next;
  logic [15:0]           byte_position, byte_position_next;
  logic [31:0]           name_capture, name_capture_next;
  logic [31:0]           string_length, string_length_next;
  logic [CHAR_IDX_W-1:0] char_index, char_index_next;
  logic [3:0]            candidate_flags, candidate_flags_next;
  logic                  string_ended, string_ended_next;

  logic                  accept;
  logic                  in_header;
  logic [63:0]           hdr_cur;
  logic [15:0]           size_cur;
  logic [15:0]           body_offset;
  logic [16:0]           position_inc;
  logic                  is_global;
  logic                  is_done;
  logic                  finish;
  logic                  error_now;
  logic                  take_ok;
  logic [CHAR_IDX_W:0]   char_inc;
  logic [2:0]            match;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      registry_object <= REGISTRY_RESET;
      callback_object <= CALLBACK_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_REGISTRY_OBJECT: registry_object <= cfg_data;
        CFG_CALLBACK_OBJECT: callback_object <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify the current byte
  always_comb begin
    in_header    = byte_position < 16'(HEADER_BYTES);
    hdr_cur      = header;
    if (in_header) begin
      hdr_cur[{byte_position[2:0], 3'b000} +: 8] = stream_byte;
    end
    size_cur     = hdr_cur[63:48];
    body_offset  = byte_position - 16'(HEADER_BYTES);
    position_inc = {1'b0, byte_position} + 17'd1;
    is_global    = (phase == PHASE_SCAN) && (hdr_cur[31:0] == registry_object)
                   && (hdr_cur[47:32] == 16'd0) && (size_cur >= 16'(MIN_GLOBAL_SIZE));
    is_done      = (hdr_cur[31:0] == callback_object) && (hdr_cur[47:32] == 16'd0);
    error_now    = in_header && (byte_position[2:0] == 3'd7)
                   && (size_cur < 16'(HEADER_BYTES));
    finish       = in_header ? ((byte_position[2:0] == 3'd7)
                                && (size_cur == 16'(HEADER_BYTES)))
                             : (position_inc >= {1'b0, size_cur});

    char_inc = {1'b0, char_index} + 1'b1;
    take_ok  = (char_index < CHAR_IDX_W'(NAME_BUFFER - 1))
               && ((|string_length[31:CHAR_IDX_W+1])
                   || (char_inc < string_length[CHAR_IDX_W:0]));

    // Body bytes of a registry global: name, length, then string compare
    name_capture_next    = name_capture;
    string_length_next   = string_length;
    char_index_next      = char_index;
    candidate_flags_next = candidate_flags;
    string_ended_next    = string_ended;
    if (!in_header && is_global) begin
      if (body_offset < 16'd4) begin
        name_capture_next[{body_offset[1:0], 3'b000} +: 8] = stream_byte;
      end else if (body_offset < 16'd8) begin
        string_length_next[{body_offset[1:0], 3'b000} +: 8] = stream_byte;
      end else if (!string_ended) begin
        if (!take_ok || stream_byte == 8'd0) begin
          string_ended_next = 1'b1;
        end else begin
          for (int i = 0; i < IFACE_COUNT; i++) begin
            if (char_index >= IFACE_LEN[i] || iface_char(2'(i), char_index) != stream_byte)
              candidate_flags_next[i] = 1'b0;
          end
          char_index_next = char_inc[CHAR_IDX_W-1:0];
        end
      end
    end

    // First surviving candidate of full length wins
    match = MATCH_NONE;
    for (int i = IFACE_COUNT - 1; i >= 0; i--) begin
      if (candidate_flags_next[i] && char_index_next == IFACE_LEN[i])
        match = 3'(i + 1);
    end

    // Build the message record
    push_msg.object_id   = hdr_cur[31:0];
    push_msg.opcode      = hdr_cur[47:32];
    push_msg.body_length = size_cur - 16'(HEADER_BYTES);
    push_msg.kind        = KIND_OTHER;
    push_msg.iface_match = MATCH_NONE;
    push_msg.global_name = 32'd0;
    if (phase == PHASE_ERR || error_now) begin
      push_msg.kind        = KIND_MALFORMED;
      push_msg.body_length = 16'd0;
    end else if (is_global) begin
      push_msg.kind        = KIND_GLOBAL;
      push_msg.iface_match = match;
      push_msg.global_name = name_capture_next;
    end else if (is_done) begin
      push_msg.kind = KIND_DONE;
    end
    push = accept && (phase == PHASE_ERR || error_now || finish);

    // Next state of the framer
    phase_next         = phase;
    header_next        = header;
    byte_position_next = byte_position;
    if (accept && phase != PHASE_ERR) begin
      if (error_now) begin
        phase_next  = PHASE_ERR;
        header_next = hdr_cur;
      end else if (finish) begin
        header_next          = 64'd0;
        byte_position_next   = 16'd0;
        name_capture_next    = 32'd0;
        string_length_next   = 32'd0;
        char_index_next      = '0;
        candidate_flags_next = 4'hf;
        string_ended_next    = 1'b0;
        if (!is_global && is_done) phase_next = PHASE_DONE;
      end else begin
        header_next        = hdr_cur;
        byte_position_next = position_inc[15:0];
      end
    end else begin
      name_capture_next    = name_capture;
      string_length_next   = string_length;
      char_index_next      = char_index;
      candidate_flags_next = candidate_flags;
      string_ended_next    = string_ended;
    end
  end

  // Hold framer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PHASE_SCAN;
      header          <= 64'd0;
      byte_position   <= 16'd0;
      name_capture    <= 32'd0;
      string_length   <= 32'd0;
      char_index      <= '0;
      candidate_flags <= 4'hf;
      string_ended    <= 1'b0;
    end else begin
      phase           <= phase_next;
      header          <= header_next;
      byte_position   <= byte_position_next;
      name_capture    <= name_capture_next;
      string_length   <= string_length_next;
      char_index      <= char_index_next;
      candidate_flags <= candidate_flags_next;
      string_ended    <= string_ended_next;
    end
  end

endmodule

// File: rtl/core/wrs_queue.sv
// Short message queue between the front and the back end.
// Depth from wrs_pkg; depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_queue import wrs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  msg_t push_msg,
  output logic full,
  input  logic pop,
  output logic empty,
  output msg_t head
);

  msg_t                 entries [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full  = count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = entries[rd_ptr];

  // Store pushed records
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_msg;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/core/wrs_back.sv
// Back end: counts globals, records matched names and drives the result register.
// Depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_back import wrs_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    queue_empty,
  input  msg_t    head,
  output logic    pop,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  logic [15:0] globals_seen, globals_seen_next;
  logic [31:0] found_names [IFACE_COUNT];
  logic [31:0] found_next  [IFACE_COUNT];
  logic [1:0]  found_sel;

  assign pop = !queue_empty && (!out_valid || out_ready);

  // Apply one message to the scan totals
  always_comb begin
    globals_seen_next = globals_seen;
    for (int i = 0; i < IFACE_COUNT; i++) found_next[i] = found_names[i];
    found_sel = 2'(head.iface_match - 3'd1);
    if (head.kind == KIND_GLOBAL) begin
      if (globals_seen != GLOBAL_COUNT_MAX) globals_seen_next = globals_seen + 16'd1;
      if (head.iface_match != MATCH_NONE) found_next[found_sel] = head.global_name;
    end
  end

  // Update totals on pop
  always_ff @(posedge clk) begin
    if (rst) begin
      globals_seen <= 16'd0;
      for (int i = 0; i < IFACE_COUNT; i++) found_names[i] <= 32'd0;
    end else if (pop) begin
      globals_seen <= globals_seen_next;
      for (int i = 0; i < IFACE_COUNT; i++) found_names[i] <= found_next[i];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      result.msg               <= head;
      result.global_count      <= globals_seen_next;
      result.compositor_global <= found_next[0];
      result.shm_global        <= found_next[1];
      result.wm_base_global    <= found_next[2];
      result.seat_global       <= found_next[3];
    end
  end

endmodule

// File: rtl/core/wayland_registry_scanner.sv
// Top level of the registry scanner: front end, message queue, back end.
// Depends on wrs_pkg, wrs_front, wrs_queue and wrs_back.
//
//   port group   direction  carries
//   s_*          in         one stream byte per transfer
//   m_*          out        one result per completed message (kind in tuser)
//   cfg_*        in         registry and callback object ids
//
// One byte is taken per cycle while the queue is not full; a message result passes
// through the queue write, then the result register, before it can transfer.
// A four-entry queue parts framing from result delivery; s_tready drops only
// when the queue is full. Reset: rst, synchronous, clears all scan state.
// After a malformed size every byte gives the same error result until reset.
`timescale 1ns / 1ps

module wayland_registry_scanner import wrs_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [31:0]            cfg_data,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [7:0]             s_tdata,   // stream_byte
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // object_id, opcode, body_length, interface_match, global_name, global_count,
  // compositor_global, shm_global, wm_base_global, seat_global, zero pad
  output logic [OUT_DATA_W-1:0]  m_tdata,
  output logic [1:0]             m_tuser    // event_kind
);

  logic    push;
  msg_t    push_msg;
  logic    queue_full;
  logic    queue_empty;
  logic    pop;
  msg_t    head;
  result_t result;

  wrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .byte_valid  (s_tvalid),
    .stream_byte (s_tdata),
    .queue_full  (queue_full),
    .byte_ready  (s_tready),
    .push        (push),
    .push_msg    (push_msg)
  );

  wrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_msg (push_msg),
    .full     (queue_full),
    .pop      (pop),
    .empty    (queue_empty),
    .head     (head)
  );

  wrs_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .result      (result)
  );

  // Pack result fields, highest first
  assign m_tdata = {
    (OUT_DATA_W - USED_DATA_W)'(0),
    result.seat_global,
    result.wm_base_global,
    result.shm_global,
    result.compositor_global,
    result.global_count,
    result.msg.global_name,
    result.msg.iface_match,
    result.msg.body_length,
    result.msg.opcode,
    result.msg.object_id
  };
  assign m_tuser = result.msg.kind;

endmodule

// File: rtl/core/wrs_checker.sv
// Port-level checks for the registry scanner, bound to the top level.
// Depends on wrs_pkg.
`timescale 1ns / 1ps

module wrs_checker import wrs_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_tvalid,
  input logic                  m_tready,
  input logic [OUT_DATA_W-1:0] m_tdata,
  input logic [1:0]            m_tuser
);

  // A stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Reset empties the result register
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Only registry globals carry a match or a global name
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_GLOBAL |->
      m_tdata[OFS_MATCH +: 3] == MATCH_NONE && m_tdata[OFS_GNAME +: 32] == 32'd0)
    else $error("non-global result carries global fields");

  // Malformed results report an empty body
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_MALFORMED |-> m_tdata[OFS_BODY_LEN +: 16] == 16'd0)
    else $error("malformed result with body length");

  // Global count never falls between back-to-back results
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) ##1 m_tvalid |->
      m_tdata[OFS_COUNT +: 16] >= $past(m_tdata[OFS_COUNT +: 16]))
    else $error("global count decreased");

endmodule

bind wayland_registry_scanner wrs_checker u_checker (.*);
